/* src/sphg_pkg.sv */
// Shared types and constants for the sampler playhead generator.
// Used by sphg_core and sampler_playhead_generator_unit; no dependencies.
package sphg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 38;
  localparam int IDX_W     = 20;
  localparam int CNT_W     = 21;
  localparam int SPAN_W    = 22;
  localparam int OFF_W     = 37;
  localparam int GRAIN_W   = 12;
  localparam int KIND_W    = 2;
  localparam int MODE_W    = 3;
  localparam int RF_W      = 16;
  localparam int SPEED_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CNT_W-1:0]   MAX_SAMPLES  = 21'd1048576;
  localparam logic [GRAIN_W-1:0] GRAIN_TICKS  = 12'd2205;
  localparam logic [SPAN_W-1:0]  START_MARGIN = 22'd10;
  localparam logic [SPAN_W-1:0]  JUMP_MARGIN  = 22'd100;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // play modes
  localparam logic [MODE_W-1:0] MODE_FWD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BWD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PP_FWD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PP_BWD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAND   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP   = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  play_mode;
    logic               loop_enable;
    logic [IDX_W-1:0]   region_start;
    logic [CNT_W-1:0]   region_end;
    logic [CNT_W-1:0]   sample_count;
    logic [SPEED_W-1:0] speed_step;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    fwd;
    logic [GRAIN_W-1:0]      grain;
    logic                    playing;
  } state_t;

  // registered item: kind plus the pre-scaled random offset
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  off;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] read_index;
    logic [IDX_W-1:0] next_index;
    logic [RF_W-1:0]  fraction;
    logic             read_valid;
    logic             is_playing;
    logic             stopped_now;
    logic             moving_forward;
  } result_t;

endpackage

/* src/sphg_core.sv */
// Per-item playhead logic: bounds, taps and step for one registered item.
// Depends on sphg_pkg.
module sphg_core (
  input  sphg_pkg::cfg_t    cfg,
  input  sphg_pkg::state_t  st,
  input  sphg_pkg::item_t   item,
  output sphg_pkg::state_t  st_next,
  output sphg_pkg::result_t res
);

  logic [sphg_pkg::MODE_W-1:0]          mode;
  logic signed [sphg_pkg::POS_W-1:0]    lo;
  logic signed [sphg_pkg::POS_W-1:0]    hi;
  logic [sphg_pkg::CNT_W-1:0]           emo;
  logic signed [sphg_pkg::POS_W-1:0]    emo_pos;
  logic signed [sphg_pkg::POS_W-1:0]    rand_pos;
  logic [sphg_pkg::GRAIN_W-1:0]         grain_inc;
  sphg_pkg::state_t                     b;       // state after start/stop/bounds
  logic                                 stopped;
  logic                                 back;
  logic signed [sphg_pkg::POS_W:0]      sum;
  logic [sphg_pkg::SPAN_W-1:0]          t0;
  logic [sphg_pkg::SPAN_W-1:0]          t1;
  logic [sphg_pkg::SPAN_W-1:0]          lim;
  logic                                 valid;

  assign mode    = (cfg.play_mode > sphg_pkg::MODE_RAND) ? sphg_pkg::MODE_RAND : cfg.play_mode;
  assign lo      = {2'b00, cfg.region_start, {sphg_pkg::FRAC_BITS{1'b0}}};
  assign hi      = {1'b0, cfg.region_end, {sphg_pkg::FRAC_BITS{1'b0}}};
  assign emo     = (cfg.region_end == '0) ? '0 : cfg.region_end - 1'b1;
  assign emo_pos = {1'b0, emo, {sphg_pkg::FRAC_BITS{1'b0}}};
  // offset is below (end - start) << 16, so this never leaves the position range
  assign rand_pos  = lo + $signed({1'b0, item.off});
  assign grain_inc = st.grain + 1'b1;

  // start, stop, region bounds and random-mode grain jumps
  always_comb begin
    b       = st;
    stopped = 1'b0;
    case (item.kind)
      sphg_pkg::KIND_START: begin
        if (cfg.sample_count != '0) begin
          case (mode)
            sphg_pkg::MODE_BWD, sphg_pkg::MODE_PP_BWD: begin
              b.pos = emo_pos;
              b.fwd = 1'b0;
            end
            sphg_pkg::MODE_RAND: begin
              b.pos = rand_pos;
              b.fwd = 1'b1;
            end
            default: begin
              b.pos = lo;
              b.fwd = 1'b1;
            end
          endcase
          b.grain   = '0;
          b.playing = 1'b1;
        end
      end
      sphg_pkg::KIND_STOP: begin
        b.playing = 1'b0;
      end
      sphg_pkg::KIND_TICK: begin
        if (st.playing) begin
          case (mode)
            sphg_pkg::MODE_FWD: begin
              if (st.pos >= hi) begin
                if (cfg.loop_enable) b.pos = lo;
                else stopped = 1'b1;
              end
            end
            sphg_pkg::MODE_BWD: begin
              if (st.pos <= lo) begin
                if (cfg.loop_enable) b.pos = emo_pos;
                else stopped = 1'b1;
              end
            end
            sphg_pkg::MODE_PP_FWD: begin
              if (st.fwd && st.pos >= hi) begin
                b.pos = emo_pos;
                b.fwd = 1'b0;
              end else if (!st.fwd && st.pos <= lo) begin
                if (cfg.loop_enable) begin
                  b.pos = lo;
                  b.fwd = 1'b1;
                end else begin
                  stopped = 1'b1;
                end
              end
            end
            sphg_pkg::MODE_PP_BWD: begin
              if (!st.fwd && st.pos <= lo) begin
                b.pos = lo;
                b.fwd = 1'b1;
              end else if (st.fwd && st.pos >= hi) begin
                if (cfg.loop_enable) begin
                  b.pos = emo_pos;
                  b.fwd = 1'b0;
                end else begin
                  stopped = 1'b1;
                end
              end
            end
            default: begin
              if (grain_inc >= sphg_pkg::GRAIN_TICKS || st.pos >= hi || st.pos < lo) begin
                b.grain = '0;
                b.pos   = rand_pos;
              end else begin
                b.grain = grain_inc;
              end
            end
          endcase
          if (stopped) b.playing = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // interpolation taps from the bounded position
  assign t0    = {1'b0, b.pos[sphg_pkg::POS_W-2:sphg_pkg::FRAC_BITS]};
  assign t1    = t0 + 1'b1;
  assign lim   = {1'b0, (cfg.sample_count > sphg_pkg::MAX_SAMPLES) ?
                        sphg_pkg::MAX_SAMPLES : cfg.sample_count};
  assign valid = (item.kind == sphg_pkg::KIND_TICK) && !b.pos[sphg_pkg::POS_W-1] && (t0 < lim);

  // step, saturated to the signed position range
  assign back = (mode == sphg_pkg::MODE_BWD) ||
                (!b.fwd && (mode == sphg_pkg::MODE_PP_FWD || mode == sphg_pkg::MODE_PP_BWD));
  assign sum  = back ? {b.pos[sphg_pkg::POS_W-1], b.pos} - $signed({15'd0, cfg.speed_step})
                     : {b.pos[sphg_pkg::POS_W-1], b.pos} + $signed({15'd0, cfg.speed_step});

  always_comb begin
    st_next = b;
    if (item.kind == sphg_pkg::KIND_TICK && b.playing) begin
      if (sum[sphg_pkg::POS_W] != sum[sphg_pkg::POS_W-1])
        st_next.pos = sum[sphg_pkg::POS_W] ? {1'b1, {(sphg_pkg::POS_W-1){1'b0}}}
                                            : {1'b0, {(sphg_pkg::POS_W-1){1'b1}}};
      else
        st_next.pos = sum[sphg_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    res.read_index     = valid ? t0[sphg_pkg::IDX_W-1:0] : '0;
    res.next_index     = '0;
    if (valid)
      res.next_index   = (t1 < lim) ? t1[sphg_pkg::IDX_W-1:0] : sphg_pkg::IDX_W'(lim - 1'b1);
    res.fraction       = valid ? b.pos[sphg_pkg::FRAC_BITS-1:0] : '0;
    res.read_valid     = valid;
    res.is_playing     = b.playing;
    res.stopped_now    = stopped;
    case (mode)
      sphg_pkg::MODE_BWD:    res.moving_forward = 1'b0;
      sphg_pkg::MODE_PP_FWD: res.moving_forward = b.fwd;
      sphg_pkg::MODE_PP_BWD: res.moving_forward = b.fwd;
      default:               res.moving_forward = 1'b1;
    endcase
  end

endmodule

/* src/sampler_playhead_generator_unit.sv */
// Top level of the sampler playhead generator: config registers, offset
// multiplier, item and result registers. Depends on sphg_pkg and sphg_core.
//
//  channel | signals                               | direction | item
//  --------+---------------------------------------+-----------+--------------------------
//  cmd     | cmd_valid, cmd_stall, kind, rand. frac | in        | start / stop / tick
//  res     | res_valid, res_stall, index/flag fields| out       | taps, fraction, flags
//  cfg     | cfg_write, cfg_index, cfg_data         | in        | register write, no wait
//
// The item register, loaded at acceptance, holds the kind and the random
// offset from the 16 x 21 multiplier; the result register, loaded when the
// item moves on, holds the outcome of the playhead logic. One item per cycle
// sustained while the result is not stalled.
// Synchronous reset clears handshake state, the playhead and the config registers.
// A stalled result holds; one further item waits in the item register.
module sampler_playhead_generator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [sphg_pkg::KIND_W-1:0]       kind,
  input  logic [sphg_pkg::RF_W-1:0]         random_fraction,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [sphg_pkg::IDX_W-1:0]        read_index,
  output logic [sphg_pkg::IDX_W-1:0]        next_index,
  output logic [sphg_pkg::RF_W-1:0]         fraction,
  output logic                              read_valid,
  output logic                              is_playing,
  output logic                              stopped_now,
  output logic                              moving_forward,
  input  logic                              cfg_write,
  input  logic [sphg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sphg_pkg::CFG_DAT_W-1:0]    cfg_data
);

  sphg_pkg::cfg_t    cfg;
  sphg_pkg::state_t  st;
  sphg_pkg::state_t  st_next;
  sphg_pkg::item_t   item;
  sphg_pkg::result_t res;
  sphg_pkg::result_t res_next;
  logic              item_valid;
  logic              adv;
  logic              accept;

  logic signed [sphg_pkg::SPAN_W-1:0] span;
  logic        [sphg_pkg::SPAN_W-1:0] margin;
  logic signed [sphg_pkg::SPAN_W-1:0] span_m;
  logic        [sphg_pkg::OFF_W-1:0]  prod;
  logic        [sphg_pkg::OFF_W-1:0]  off;

  // ---- configuration registers (the user must write them only while idle; the block has no guard) ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.play_mode    <= '0;
      cfg.loop_enable  <= 1'b0;
      cfg.region_start <= '0;
      cfg.region_end   <= sphg_pkg::CNT_W'(1);
      cfg.sample_count <= '0;
      cfg.speed_step   <= sphg_pkg::SPEED_W'(65536);
    end else if (cfg_write) begin
      case (cfg_index)
        sphg_pkg::REG_PLAY_MODE:    cfg.play_mode    <= cfg_data[sphg_pkg::MODE_W-1:0];
        sphg_pkg::REG_LOOP_ENABLE:  cfg.loop_enable  <= cfg_data[0];
        sphg_pkg::REG_REGION_START: cfg.region_start <= cfg_data[sphg_pkg::IDX_W-1:0];
        sphg_pkg::REG_REGION_END:   cfg.region_end   <= cfg_data[sphg_pkg::CNT_W-1:0];
        sphg_pkg::REG_SAMPLE_COUNT: cfg.sample_count <= cfg_data[sphg_pkg::CNT_W-1:0];
        sphg_pkg::REG_SPEED_STEP:   cfg.speed_step   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---- random offset: fraction x (span - margin), margin by item kind ----
  // 10 samples of margin at start, 100 on a grain jump; zero if span too short.
  assign span   = $signed({1'b0, cfg.region_end}) - $signed({2'b00, cfg.region_start});
  assign margin = (kind == sphg_pkg::KIND_START) ? sphg_pkg::START_MARGIN
                                                 : sphg_pkg::JUMP_MARGIN;
  assign span_m = span - $signed(margin);
  assign prod   = sphg_pkg::OFF_W'(random_fraction) *
                  sphg_pkg::OFF_W'(span_m[sphg_pkg::CNT_W-1:0]);
  assign off    = (span > $signed(margin)) ? prod : '0;

  // ---- handshake ----
  // result register frees when empty or taken; item register moves on then
  assign adv       = item_valid && (!res_valid || !res_stall);
  assign cmd_stall = item_valid && !adv;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!cmd_stall) begin
      item_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind <= kind;
      item.off  <= off;
    end
  end

  // ---- playhead logic ----
  sphg_core u_core (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pos     <= '0;
      st.fwd     <= 1'b1;
      st.grain   <= '0;
      st.playing <= 1'b0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res <= res_next;
  end

  assign read_index     = res.read_index;
  assign next_index     = res.next_index;
  assign fraction       = res.fraction;
  assign read_valid     = res.read_valid;
  assign is_playing     = res.is_playing;
  assign stopped_now    = res.stopped_now;
  assign moving_forward = res.moving_forward;

  // ---- assertions ----
  a_grain_range: assert property (@(posedge clk) disable iff (rst)
    st.grain < sphg_pkg::GRAIN_TICKS)
    else $error("grain counter beyond jump period");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    adv && item.kind == sphg_pkg::KIND_STOP |=> res_valid && !is_playing && !st.playing)
    else $error("stop item left playback running");

  a_stopped_not_playing: assert property (@(posedge clk) disable iff (rst)
    res_valid && stopped_now |-> !is_playing && !read_valid || !is_playing)
    else $error("stopped result still playing");

  a_taps_adjacent: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_valid |->
      next_index == read_index || next_index == read_index + 1'b1)
    else $error("second tap not next to first");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !read_valid |-> read_index == '0 && next_index == '0 && fraction == '0)
    else $error("invalid read carries tap data");

endmodule

/* verif/playhead_check_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the sampler playhead generator: its own playhead predictor,
// a register copy and the queue of expected tap results. Depends on sphg_pkg.
package playhead_check_pkg;
  import sphg_pkg::*;

  localparam longint POS_TOP = (longint'(1) <<< (POS_W - 1)) - 1;

  class playhead_scoreboard;
    // register copy
    logic [MODE_W-1:0]  play_mode;
    logic               loop_enable;
    logic [IDX_W-1:0]   region_start;
    logic [CNT_W-1:0]   region_end;
    logic [CNT_W-1:0]   sample_count;
    logic [SPEED_W-1:0] speed_step;
    // playhead state
    longint      position;
    bit          forward;
    int unsigned grain;
    bit          playing;

    result_t     expected_taps[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned kind_seen[4];
    int unsigned bound_stops;
    int unsigned grain_jumps;

    function new();
      play_mode    = MODE_FWD;
      loop_enable  = 1'b0;
      region_start = '0;
      region_end   = 1;
      sample_count = '0;
      speed_step   = 24'd65536;
      position     = 0;
      forward      = 1'b1;
      grain        = 0;
      playing      = 1'b0;
      mismatches   = 0;
      checked      = 0;
      bound_stops  = 0;
      grain_jumps  = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_PLAY_MODE:    play_mode    = data[MODE_W-1:0];
        REG_LOOP_ENABLE:  loop_enable  = data[0];
        REG_REGION_START: region_start = data[IDX_W-1:0];
        REG_REGION_END:   region_end   = data[CNT_W-1:0];
        REG_SAMPLE_COUNT: sample_count = data[CNT_W-1:0];
        REG_SPEED_STEP:   speed_step   = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_pos(longint v);
      if (v > POS_TOP) return POS_TOP;
      if (v < -POS_TOP - 1) return -POS_TOP - 1;
      return v;
    endfunction

    // 2^-16 units to playhead fraction units
    function longint to_frac(longint v);
      if (FRAC_BITS >= 16) return v <<< (FRAC_BITS - 16);
      return v >>> (16 - FRAC_BITS);
    endfunction

    // region start plus a random share of the span less the margin
    function longint random_place(logic [RF_W-1:0] rf, longint margin);
      longint span;
      longint base;
      span = longint'(region_end) - longint'(region_start);
      base = longint'(region_start) <<< FRAC_BITS;
      if (span > margin) base += to_frac(longint'(rf) * (span - margin));
      return clamp_pos(base);
    endfunction

    // advance the playhead by one item and queue the result it produces
    function void note_item(logic [KIND_W-1:0] k, logic [RF_W-1:0] rf);
      result_t           r;
      logic [MODE_W-1:0] mode;
      longint            lo, hi, top, p, lim, t0;
      bit                stop_hit, back;
      r        = '0;
      stop_hit = 1'b0;
      mode     = (play_mode > MODE_RAND) ? MODE_RAND : play_mode;
      lo       = longint'(region_start) <<< FRAC_BITS;
      hi       = longint'(region_end) <<< FRAC_BITS;
      top      = clamp_pos(((region_end > 0) ? longint'(region_end) - 1 : 0) <<< FRAC_BITS);
      kind_seen[k]++;

      case (k)
        KIND_START: begin
          if (sample_count != 0) begin
            if (mode == MODE_BWD || mode == MODE_PP_BWD) begin
              position = top;
              forward  = 1'b0;
            end else if (mode == MODE_RAND) begin
              position = random_place(rf, START_MARGIN);
              forward  = 1'b1;
            end else begin
              position = clamp_pos(lo);
              forward  = 1'b1;
            end
            grain   = 0;
            playing = 1'b1;
          end
        end
        KIND_STOP: playing = 1'b0;
        KIND_TICK: begin
          if (playing) begin
            p = position;
            case (mode)
              MODE_FWD: begin
                if (p >= hi) begin
                  if (loop_enable) position = clamp_pos(lo);
                  else stop_hit = 1'b1;
                end
              end
              MODE_BWD: begin
                if (p <= lo) begin
                  if (loop_enable) position = top;
                  else stop_hit = 1'b1;
                end
              end
              MODE_PP_FWD: begin
                // first bound always turns, the other loops or stops
                if (forward && p >= hi) begin
                  position = top;
                  forward  = 1'b0;
                end else if (!forward && p <= lo) begin
                  if (loop_enable) begin
                    position = clamp_pos(lo);
                    forward  = 1'b1;
                  end else begin
                    stop_hit = 1'b1;
                  end
                end
              end
              MODE_PP_BWD: begin
                if (!forward && p <= lo) begin
                  position = clamp_pos(lo);
                  forward  = 1'b1;
                end else if (forward && p >= hi) begin
                  if (loop_enable) begin
                    position = top;
                    forward  = 1'b0;
                  end else begin
                    stop_hit = 1'b1;
                  end
                end
              end
              default: begin
                grain = (grain + 1) & 12'hFFF;
                if (grain >= GRAIN_TICKS || p >= hi || p < lo) begin
                  if (grain >= GRAIN_TICKS) grain_jumps++;
                  grain    = 0;
                  position = random_place(rf, JUMP_MARGIN);
                end
              end
            endcase
            if (stop_hit) begin
              playing = 1'b0;
              bound_stops++;
            end
          end

          // taps of the position before stepping
          if (position >= 0) begin
            t0  = position >>> FRAC_BITS;
            lim = (sample_count < MAX_SAMPLES) ? longint'(sample_count) : longint'(MAX_SAMPLES);
            if (t0 < lim) begin
              r.read_valid = 1'b1;
              r.read_index = IDX_W'(t0);
              r.next_index = IDX_W'((t0 + 1 < lim) ? t0 + 1 : lim - 1);
              r.fraction   = RF_W'((position & ((longint'(1) <<< FRAC_BITS) - 1))
                                   >>> (FRAC_BITS - RF_W));
            end
          end

          if (playing) begin
            back = (mode == MODE_BWD) ||
                   (!forward && (mode == MODE_PP_FWD || mode == MODE_PP_BWD));
            position = clamp_pos(back ? position - to_frac(longint'(speed_step))
                                      : position + to_frac(longint'(speed_step)));
          end
        end
        default: ;  // no-op kind: state untouched
      endcase

      r.is_playing  = playing;
      r.stopped_now = stop_hit;
      if (mode == MODE_BWD) r.moving_forward = 1'b0;
      else if (mode == MODE_PP_FWD || mode == MODE_PP_BWD) r.moving_forward = forward;
      else r.moving_forward = 1'b1;
      expected_taps.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got_v);
      if (got_v !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_taps.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual index %0d valid %0b",
                 $time, got.read_index, got.read_valid);
        return;
      end
      want = expected_taps.pop_front();
      checked++;
      compare_field("read_index", want.read_index, got.read_index);
      compare_field("next_index", want.next_index, got.next_index);
      compare_field("fraction", want.fraction, got.fraction);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("is_playing", want.is_playing, got.is_playing);
      compare_field("stopped_now", want.stopped_now, got.stopped_now);
      compare_field("moving_forward", want.moving_forward, got.moving_forward);
    endfunction
  endclass

endpackage

/* verif/tb_sampler_playhead_generator_unit.sv */
`timescale 1ns / 1ps
// Top-level testbench for sampler_playhead_generator_unit: drives start, stop, tick
// and no-op items under varied registers. Depends on sphg_pkg and playhead_check_pkg.
module tb_sampler_playhead_generator_unit;
  import sphg_pkg::*;
  import playhead_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int RANDOM_ITEMS = 650;
  localparam int GRAIN_ITEMS  = 80;    // ticks on a near-still random-mode playhead
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;  // unused kind, no state change

  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 cmd_valid       = 1'b0;
  logic                 cmd_stall;
  logic [KIND_W-1:0]    kind            = KIND_STOP;
  logic [RF_W-1:0]      random_fraction = '0;
  logic                 res_valid;
  logic                 res_stall       = 1'b0;
  logic [IDX_W-1:0]     read_index;
  logic [IDX_W-1:0]     next_index;
  logic [RF_W-1:0]      fraction;
  logic                 read_valid;
  logic                 is_playing;
  logic                 stopped_now;
  logic                 moving_forward;
  logic                 cfg_write       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_PLAY_MODE;
  logic [CFG_DAT_W-1:0] cfg_data        = '0;

  playhead_scoreboard sb;

  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;  // items left in the current sender burst
  int unsigned hold_requests = 0;  // raised by the stimulus process only
  int unsigned holds_served  = 0;  // advanced by the receiver only
  int          hold_left     = 0;
  int          seg_left      = 0;
  int          stall_pct     = 0;
  int          phases        = 0;

  sampler_playhead_generator_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: checks each accepted result, then picks the next stall value.
  // Stalls follow segments of random length and density; a hold request
  // from the stimulus side forces a long unbroken stall.
  always @(posedge clk) begin
    result_t got;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got.read_index     = read_index;
        got.next_index     = next_index;
        got.fraction       = fraction;
        got.read_valid     = read_valid;
        got.is_playing     = is_playing;
        got.stopped_now    = stopped_now;
        got.moving_forward = moving_forward;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES - 1;
        res_stall    <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(4, 50);
          case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 60;
            default: stall_pct <= 90;
          endcase
        end else begin
          seg_left <= seg_left - 1;
        end
        res_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // One register write, taken at the next rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [CFG_DAT_W-1:0] mode, lp, rs, re, cnt, spd);
    write_reg(REG_PLAY_MODE, mode);
    write_reg(REG_LOOP_ENABLE, lp);
    write_reg(REG_REGION_START, rs);
    write_reg(REG_REGION_END, re);
    write_reg(REG_SAMPLE_COUNT, cnt);
    write_reg(REG_SPEED_STEP, spd);
    cfg_write <= 1'b0;
    phases++;
  endtask

  // Offer one item and wait for it to be taken. The sender works in bursts;
  // between bursts valid drops for a random gap, or not at all.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [RF_W-1:0] rf);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_valid       <= 1'b1;
    kind            <= k;
    random_fraction <= rf;
    do @(posedge clk); while (cmd_stall);
    sb.note_item(k, rf);
  endtask

  // A play sequence: a start, then mostly ticks with the odd start, stop or no-op.
  task automatic run_items(input int n, input int tick_pct);
    int pick;
    send_item(KIND_START, RF_W'($urandom_range(0, 16'hFFFF)));
    for (int i = 1; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        send_item(KIND_TICK, RF_W'($urandom_range(0, 16'hFFFF)));
      end else begin
        case (pick % 4)
          0, 1: send_item(KIND_START, RF_W'($urandom_range(0, 16'hFFFF)));
          2: send_item(KIND_STOP, RF_W'($urandom_range(0, 16'hFFFF)));
          default: send_item(KIND_NOP, RF_W'($urandom_range(0, 16'hFFFF)));
        endcase
      end
    end
  endtask

  // Sender pauses until every expected result is back, then lets the block settle.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.expected_taps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned          random_sent;
    int                   n;
    logic [CFG_DAT_W-1:0] mode_d, loop_d, rs, re, cnt, spd;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: empty memory, so the start is ignored
    send_item(KIND_START, 16'hFFFF);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_NOP, 16'hFFFF);
    send_item(KIND_STOP, 16'h0000);
    drain();

    // forward, no loop: runs into the region end and stops there
    load_settings(CFG_DAT_W'(MODE_FWD), 0, 2, 4, 8, 24'h010000);
    send_item(KIND_START, 16'h0000);
    repeat (4) send_item(KIND_TICK, 16'h0000);
    drain();

    // random mode, span under the margin, memory beyond the limit, top speed
    load_settings(CFG_DAT_W'(MODE_RAND), 1, 100, 105, 24'h1FFFFF, 24'hFFFFFF);
    send_item(KIND_START, 16'hFFFF);
    repeat (2) send_item(KIND_TICK, 16'hFFFF);
    drain();

    // ping-pong backward first with region end zero: turn, then stop at the end
    load_settings(CFG_DAT_W'(MODE_PP_BWD), 0, 0, 0, 1, 24'h008000);
    send_item(KIND_START, 16'h0000);
    repeat (2) send_item(KIND_TICK, 16'h0000);
    drain();

    // backward, no loop: steps below zero and reads as invalid
    load_settings(CFG_DAT_W'(MODE_BWD), 0, 0, 3, 3, 24'h018000);
    send_item(KIND_START, 16'h0000);
    repeat (4) send_item(KIND_TICK, 16'h0000);
    drain();

    // ping-pong forward first with loop: turn at the end, loop at the start
    load_settings(CFG_DAT_W'(MODE_PP_FWD), 1, 1, 2, 3, 24'h010000);
    send_item(KIND_START, 16'hFFFF);
    repeat (3) send_item(KIND_TICK, 16'hFFFF);
    drain();

    // random phases; first all registers at their top, then all at zero
    random_sent = 0;
    for (int ph = 0; random_sent < RANDOM_ITEMS; ph++) begin
      if (ph == 0) begin
        mode_d = 24'hFFFFFF; loop_d = 24'hFFFFFF; rs = 24'h0FFFFF;
        re = 24'h1FFFFF; cnt = 24'h1FFFFF; spd = 24'hFFFFFF;
      end else if (ph == 1) begin
        mode_d = 0; loop_d = 0; rs = 0; re = 0; cnt = 0; spd = 0;
      end else begin
        mode_d = ($urandom_range(0, 9) < 8) ? CFG_DAT_W'($urandom_range(0, 4))
                                            : CFG_DAT_W'($urandom_range(5, 7));
        loop_d = CFG_DAT_W'($urandom_range(0, 1));
        // unused upper data bits now and then
        if ($urandom_range(0, 3) == 0) begin
          mode_d = mode_d | (CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)) & 24'hFFFFF8);
          loop_d = loop_d | (CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)) & 24'hFFFFFE);
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: rs = CFG_DAT_W'($urandom_range(0, 200));
          6, 7: rs = CFG_DAT_W'($urandom_range(0, 20'hFFFFF));
          8: rs = 0;
          default: rs = 20'hFFFFF;
        endcase
        // mostly short regions so that bounds come up within a phase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: re = rs + CFG_DAT_W'($urandom_range(1, 40));
          7: re = rs + CFG_DAT_W'($urandom_range(41, 3000));
          8: re = CFG_DAT_W'($urandom_range(0, rs));  // empty or inverted region
          default: re = CFG_DAT_W'($urandom_range(0, 21'h1FFFFF));
        endcase
        re = re & 24'h1FFFFF;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: cnt = (re + CFG_DAT_W'($urandom_range(0, 5))) & 24'h1FFFFF;
          6, 7: cnt = CFG_DAT_W'($urandom_range(0, re));  // memory no longer than the region
          8: cnt = 0;
          default: cnt = CFG_DAT_W'($urandom_range(0, 21'h1FFFFF));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: spd = CFG_DAT_W'($urandom_range(24'h001000, 24'h040000));
          6: spd = 0;
          7: spd = 24'hFFFFFF;
          default: spd = CFG_DAT_W'($urandom_range(0, 24'hFFFFFF));
        endcase
      end
      load_settings(mode_d, loop_d, rs, re, cnt, spd);
      // receiver hold-off while the sender keeps offering items
      if (ph == 2 || $urandom_range(0, 6) == 0) hold_requests <= hold_requests + 1;
      n = $urandom_range(10, 40);
      run_items(n, 86);
      random_sent += n;
      drain();
    end

    // random mode with a near-still playhead over a long region
    load_settings(CFG_DAT_W'(MODE_RAND), CFG_DAT_W'($urandom_range(0, 1)), 0, 4000, 4000, 1);
    run_items(GRAIN_ITEMS, 100);
    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d register settings: %0d starts, %0d stops, %0d ticks, %0d no-ops.",
             phases, sb.kind_seen[KIND_START], sb.kind_seen[KIND_STOP],
             sb.kind_seen[KIND_TICK], sb.kind_seen[KIND_NOP]);
    $display("%0d results checked; %0d stops at a bound, %0d grain-count jumps.",
             sb.checked, sb.bound_stops, sb.grain_jumps);
    if (sb.mismatches == 0 && sb.expected_taps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
